// ===== sv/nctx_pkg.sv =====
// Shared types and constants for the NFC Type A card transmit bit encoder.
`timescale 1ns / 1ps

package nctx_pkg;

    localparam logic [15:0] PATTERN_ONE  = 16'hAA00;
    localparam logic [15:0] PATTERN_ZERO = 16'h00AA;
    localparam logic [3:0]  BYTE_BITS    = 4'd8;
    localparam int          QUEUE_DEPTH_DEFAULT = 2;

    // One classified frame byte: which symbols it produces and their source bits.
    typedef struct packed {
        logic       sof;
        logic [7:0] data;
        logic       parity;
        logic [3:0] nbits;
        logic       par;
    } sym_desc_t;

endpackage

// ===== sv/nctx_front.sv =====
// Front stage: accepts frame bytes and classifies them into symbol descriptors.
`timescale 1ns / 1ps

module nctx_front
    import nctx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       parity_bit,
    input  logic [3:0] bit_count,
    input  logic       frame_start,
    output logic       desc_valid,
    output sym_desc_t  desc,
    input  logic       queue_full
);

    logic      valid_reg;
    logic      valid_next;
    sym_desc_t desc_reg;
    sym_desc_t desc_next;
    logic      accept;
    logic      transfer;
    logic      full_byte;

    assign full_byte = (bit_count >= BYTE_BITS);

    always_comb
    begin
        desc_next.sof    = frame_start;
        desc_next.data   = data_byte;
        desc_next.parity = parity_bit;
        desc_next.nbits  = full_byte ? BYTE_BITS : bit_count;
        desc_next.par    = full_byte;
    end

    assign full     = valid_reg && queue_full;
    assign accept   = push && !full;
    assign transfer = valid_reg && !queue_full;

    // An item that yields no symbol at all is dropped here.
    assign valid_next = accept ? (frame_start || (bit_count != 4'd0))
                               : (valid_reg && !transfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desc_reg <= desc_next;
        end
    end

    assign desc_valid = transfer;
    assign desc       = desc_reg;

endmodule

// ===== sv/nctx_queue.sv =====
// Short descriptor queue between the front and back stages.
`timescale 1ns / 1ps

module nctx_queue
    import nctx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  sym_desc_t wr_data,
    output logic      q_full,
    input  logic      rd_en,
    output logic      q_valid,
    output sym_desc_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sym_desc_t           mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/nctx_back.sv =====
// Back stage: steps a descriptor, emits one bit symbol per cycle unless stalled.
`timescale 1ns / 1ps

module nctx_back
    import nctx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        desc_valid,
    input  sym_desc_t   desc,
    output logic        desc_done,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] bit_pattern,
    output logic        data_bit,
    output logic        is_sof,
    output logic        is_parity,
    output logic        last_of_item
);

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] pattern_reg;
    logic        bit_reg;
    logic        sof_reg;
    logic        par_reg;
    logic        last_reg;

    logic        advance;
    logic [3:0]  total;
    logic [3:0]  data_idx;
    logic        sym_sof;
    logic        sym_par;
    logic        sym_bit;
    logic        sym_last;

    assign total    = {3'd0, desc.sof} + desc.nbits + {3'd0, desc.par};
    assign data_idx = step_reg - {3'd0, desc.sof};
    assign sym_sof  = desc.sof && (step_reg == 4'd0);
    assign sym_par  = !sym_sof && (data_idx >= desc.nbits);
    assign sym_last = (step_reg == total - 4'd1);

    always_comb
    begin
        priority if (sym_sof)
        begin
            sym_bit = 1'b1;
        end
        else if (sym_par)
        begin
            sym_bit = desc.parity;
        end
        else
        begin
            sym_bit = desc.data[data_idx[2:0]];
        end
    end

    // The output register is refilled in the same cycle it is popped.
    assign advance   = desc_valid && (!out_valid_reg || pop);
    assign desc_done = advance && sym_last;

    assign step_next      = advance ? (sym_last ? 4'd0 : step_reg + 4'd1) : step_reg;
    assign out_valid_next = advance || (out_valid_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pattern_reg <= sym_bit ? PATTERN_ONE : PATTERN_ZERO;
            bit_reg     <= sym_bit;
            sof_reg     <= sym_sof;
            par_reg     <= sym_par;
            last_reg    <= sym_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign bit_pattern  = pattern_reg;
    assign data_bit     = bit_reg;
    assign is_sof       = sof_reg;
    assign is_parity    = par_reg;
    assign last_of_item = last_reg;

endmodule

// ===== sv/nfca_card_tx_bit_encoder.sv =====
// Top level of the NFC Type A card transmit bit encoder.
//
//  Channel  | Handshake    | Payload
//  ---------+--------------+-----------------------------------------------
//  input    | push / full  | data_byte, parity_bit, bit_count, frame_start
//  result   | pop / empty  | bit_pattern, data_bit, is_sof, is_parity,
//           |              | last_of_item
//
// The back stage emits one symbol per cycle unless the result stalls, so
// a byte yields 1 to 10 symbols (start-of-frame, data bits and parity);
// the symbol stepper sets the rate. A transfer in is registered by the
// front stage, written into the queue and loaded into the result register.
// Reset clears all control state. A stalled result holds the back stage;
// the queue and front stage keep taking bytes until they are full.
`timescale 1ns / 1ps

module nfca_card_tx_bit_encoder
    import nctx_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        parity_bit,
    input  logic [3:0]  bit_count,
    input  logic        frame_start,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] bit_pattern,
    output logic        data_bit,
    output logic        is_sof,
    output logic        is_parity,
    output logic        last_of_item
);

    logic      front_valid;
    sym_desc_t front_desc;
    logic      queue_full;
    logic      queue_valid;
    sym_desc_t queue_desc;
    logic      desc_done;

    nctx_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .parity_bit  (parity_bit),
        .bit_count   (bit_count),
        .frame_start (frame_start),
        .desc_valid  (front_valid),
        .desc        (front_desc),
        .queue_full  (queue_full)
    );

    nctx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_desc),
        .q_full  (queue_full),
        .rd_en   (desc_done),
        .q_valid (queue_valid),
        .rd_data (queue_desc)
    );

    nctx_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_valid   (queue_valid),
        .desc         (queue_desc),
        .desc_done    (desc_done),
        .empty        (empty),
        .pop          (pop),
        .bit_pattern  (bit_pattern),
        .data_bit     (data_bit),
        .is_sof       (is_sof),
        .is_parity    (is_parity),
        .last_of_item (last_of_item)
    );

endmodule

// ===== bench/nfca_card_tx_bit_encoder_test.sv =====
// Self-checking testbench for the NFC Type A card transmit bit encoder.
`timescale 1ns / 1ps

module nfca_card_tx_bit_encoder_test;
    import nctx_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       parity;
        logic [3:0] nbits;
        logic       sof;
    } frame_byte_t;

    typedef struct {
        logic [15:0] pattern;
        logic        value;
        logic        sof;
        logic        par;
        logic        last;
    } bit_symbol_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'd0;
    logic        parity_bit = 1'b0;
    logic [3:0]  bit_count = 4'd0;
    logic        frame_start = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] bit_pattern;
    logic        data_bit;
    logic        is_sof;
    logic        is_parity;
    logic        last_of_item;

    frame_byte_t pending_bytes[$];
    bit_symbol_t expected_symbols[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int symbols_checked = 0;
    int sof_symbols = 0;
    int parity_symbols = 0;

    nfca_card_tx_bit_encoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .parity_bit   (parity_bit),
        .bit_count    (bit_count),
        .frame_start  (frame_start),
        .empty        (empty),
        .pop          (pop),
        .bit_pattern  (bit_pattern),
        .data_bit     (data_bit),
        .is_sof       (is_sof),
        .is_parity    (is_parity),
        .last_of_item (last_of_item)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit_symbol_t make_symbol(logic value, logic sof, logic par);
        bit_symbol_t s;
        s.pattern = value ? PATTERN_ONE : PATTERN_ZERO;
        s.value   = value;
        s.sof     = sof;
        s.par     = par;
        s.last    = 1'b0;
        return s;
    endfunction

    // Expands one frame byte into the symbols it must produce on the air.
    function automatic void encode_byte(frame_byte_t b);
        bit_symbol_t syms[$];
        int          nbits;
        if (b.sof)
            syms.push_back(make_symbol(1'b1, 1'b1, 1'b0));
        // Counts above a full byte behave like a full byte.
        nbits = (b.nbits >= BYTE_BITS) ? int'(BYTE_BITS) : int'(b.nbits);
        for (int i = 0; i < nbits; i++)
            syms.push_back(make_symbol(b.data[i], 1'b0, 1'b0));
        if (b.nbits >= BYTE_BITS)
            syms.push_back(make_symbol(b.parity, 1'b0, 1'b1));
        if (syms.size() > 0)
            syms[syms.size() - 1].last = 1'b1;
        foreach (syms[i])
            expected_symbols.push_back(syms[i]);
    endfunction

    function automatic void add_byte(logic [7:0] data, logic parity, logic [3:0] nbits,
                                     logic sof);
        frame_byte_t b;
        b.data   = data;
        b.parity = parity;
        b.nbits  = nbits;
        b.sof    = sof;
        pending_bytes.push_back(b);
    endfunction

    // Mostly well-formed frames with random content, mixed with short frames and noise.
    task automatic add_random_bytes(int n);
        int added;
        int r;
        int len;
        logic [3:0] nbits;
        logic sof;
        added = 0;
        while (added < n)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    nbits = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : BYTE_BITS;
                    add_byte(8'($urandom), 1'($urandom), nbits, k == 0);
                end
                added += len;
            end
            else if (r < 85)
            begin
                add_byte(8'($urandom), 1'($urandom), 4'($urandom_range(1, 7)), 1'b1);
                added++;
            end
            else
            begin
                nbits = 4'($urandom_range(0, 15));
                sof   = 1'($urandom);
                add_byte(8'($urandom), 1'($urandom), nbits, sof);
                if (nbits != 4'd0 || sof)
                    added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || push || expected_symbols.size() > 0)
            @(posedge clk);
    endtask

    // Driver: a transfer happens at an edge where push is high and full is low.
    always @(posedge clk)
    begin
        frame_byte_t b;
        if (!rst_n)
            push <= 1'b0;
        else if (!(push && full))
        begin
            if (push)
            begin
                b.data   = data_byte;
                b.parity = parity_bit;
                b.nbits  = bit_count;
                b.sof    = frame_start;
                encode_byte(b);
                bytes_sent++;
            end
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                b = pending_bytes.pop_front();
                push        <= 1'b1;
                data_byte   <= b.data;
                parity_bit  <= b.parity;
                bit_count   <= b.nbits;
                frame_start <= b.sof;
            end
            else
                push <= 1'b0;
        end
    end

    // Monitor: checks every symbol transfer against the oldest expectation.
    always @(posedge clk)
    begin
        bit_symbol_t e;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $error("unexpected symbol: bit_pattern=%h data_bit=%b", bit_pattern,
                           data_bit);
                    error_count++;
                end
                else
                begin
                    e = expected_symbols.pop_front();
                    symbols_checked++;
                    if (e.sof)
                        sof_symbols++;
                    if (e.par)
                        parity_symbols++;
                    if (bit_pattern !== e.pattern)
                    begin
                        $error("bit_pattern: expected %h, got %h", e.pattern, bit_pattern);
                        error_count++;
                    end
                    if (data_bit !== e.value)
                    begin
                        $error("data_bit: expected %b, got %b", e.value, data_bit);
                        error_count++;
                    end
                    if (is_sof !== e.sof)
                    begin
                        $error("is_sof: expected %b, got %b", e.sof, is_sof);
                        error_count++;
                    end
                    if (is_parity !== e.par)
                    begin
                        $error("is_parity: expected %b, got %b", e.par, is_parity);
                        error_count++;
                    end
                    if (last_of_item !== e.last)
                    begin
                        $error("last_of_item: expected %b, got %b", e.last, last_of_item);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed bytes: field extremes, oversized counts, short and empty items.
        add_byte(8'h00, 1'b0, BYTE_BITS, 1'b1);
        add_byte(8'hFF, 1'b1, BYTE_BITS, 1'b0);
        add_byte(8'hA5, 1'b1, BYTE_BITS, 1'b0);
        add_byte(8'h5A, 1'b0, BYTE_BITS, 1'b0);
        add_byte(8'h01, 1'b1, 4'd9, 1'b1);
        add_byte(8'h80, 1'b0, 4'd12, 1'b0);
        add_byte(8'hFF, 1'b1, 4'd15, 1'b0);
        add_byte(8'hFF, 1'b1, 4'd0, 1'b0);
        add_byte(8'h00, 1'b1, 4'd0, 1'b1);
        for (int n = 1; n < 8; n++)
            add_byte(8'($urandom), 1'b1, 4'(n), 1'b1);
        add_byte(8'h26, 1'b0, 4'd7, 1'b1);
        add_byte(8'h7F, 1'b0, 4'd7, 1'b0);
        add_byte(8'hFE, 1'b1, 4'd1, 1'b0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random_bytes(100);
        wait_drained();

        send_idle_pct  = 87;
        recv_stall_pct = 0;
        add_random_bytes(100);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 87;
        add_random_bytes(100);
        wait_drained();

        send_idle_pct  = 21;
        recv_stall_pct = 21;
        add_random_bytes(100);
        wait_drained();

        // Let any stray symbol surface while the monitor keeps popping.
        recv_stall_pct = 0;
        repeat (20) @(posedge clk);

        $display("Sent %0d frame bytes and checked %0d bit symbols,", bytes_sent,
                 symbols_checked);
        $display("including %0d start-of-frame and %0d parity symbols.", sof_symbols,
                 parity_symbols);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Timed out waiting for the encoder.");
        $display("== FAIL ==");
        $finish;
    end

endmodule
